// ===== rtl/two_level_page_table_engine_top_defines.svh =====
// Assertion macros for the two-level page table engine.
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define TLPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlpt_pkg.sv =====
// Shared types and constants of the two-level page table engine.
package tlpt_pkg;

    localparam int IDX_W          = 10;
    localparam int FRAME_W        = 20;
    localparam int DESC_W         = 23;
    localparam int SECOND_ENTRIES = 1024;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 24;
    localparam int Q_DEPTH        = 4;
    localparam int Q_AW           = 2;

    // operation codes
    localparam logic [1:0] OP_MAP    = 2'd0;
    localparam logic [1:0] OP_UNMAP  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOMEM  = 2'd1;
    localparam logic [1:0] ST_EXISTS = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // cache policies
    localparam logic [1:0] CP_NORMAL      = 2'd0;
    localparam logic [1:0] CP_FRAMEBUFFER = 2'd1;
    localparam logic [1:0] CP_MEM_NOCACHE = 2'd2;
    localparam logic [1:0] CP_IO_NOCACHE  = 2'd3;

    // descriptor layout
    localparam int DESC_VALID_BIT = 0;
    localparam int DESC_WP_BIT    = 1;
    localparam int DESC_CI_BIT    = 2;
    localparam int DESC_FRAME_LSB = 3;

    typedef struct packed {
        logic [1:0]         op;
        logic [IDX_W-1:0]   top_idx;
        logic [IDX_W-1:0]   sec_idx;
        logic [FRAME_W-1:0] frame;
        logic               wp;
        logic               ci;
        logic               rel;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
        logic               isw;
        logic               isu;
        logic               tlb;
        logic               rel;
    } res_t;

endpackage

// ===== rtl/tlpt_front.sv =====
// Front end: accepts request items and decodes them into queue commands.
module tlpt_front (
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tlpt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]                     s_axis_tuser,
    input  tlpt_pkg::q_stat_t              q_stat,
    input  logic                           busy,
    output logic                           push,
    output tlpt_pkg::cmd_t                 cmd
);
    import tlpt_pkg::*;

    assign s_axis_tready = !q_stat.full && !busy;
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cmd.op      = s_axis_tuser;
        cmd.top_idx = s_axis_tdata[19:10];
        cmd.sec_idx = s_axis_tdata[9:0];
        cmd.frame   = s_axis_tdata[39:20];
        cmd.wp      = !s_axis_tdata[40];
        cmd.ci      = s_axis_tdata[42:41] inside {CP_MEM_NOCACHE, CP_IO_NOCACHE};
        cmd.rel     = s_axis_tdata[43];
    end

endmodule

// ===== rtl/tlpt_queue.sv =====
// Short command queue between the front end and the table walker.
module tlpt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tlpt_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output tlpt_pkg::cmd_t    head_cmd,
    output tlpt_pkg::q_stat_t q_stat
);
    import tlpt_pkg::*;

    cmd_t            slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;

    assign head_cmd     = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/tlpt_back.sv =====
// Table walker: clears the tables, runs each command, holds the result register.
module tlpt_back #(
    parameter int POOL_TABLES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tlpt_pkg::cmd_t    head_cmd,
    input  tlpt_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output tlpt_pkg::res_t    out_res
);
    import tlpt_pkg::*;

    localparam int TW         = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int NFW        = $clog2(POOL_TABLES + 1);
    localparam int DESC_DEPTH = POOL_TABLES * SECOND_ENTRIES;
    localparam int DAW        = $clog2(DESC_DEPTH);
    localparam int TOP_DEPTH  = 1 << IDX_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_TOP   = 2'd2;
    localparam logic [1:0] S_DESC  = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [DAW-1:0] clr_reg, clr_next;
    logic [NFW-1:0] next_free_reg, next_free_next;
    cmd_t           cmd_reg, cmd_next;
    logic [DAW-1:0] di_reg, di_next;
    logic           out_valid_reg, out_valid_next;
    res_t           res_reg, res_next;

    // top table: valid bit over pool table index
    logic [TW:0]      top_mem [TOP_DEPTH];
    logic [TW:0]      top_rd_reg;
    logic             top_we;
    logic [IDX_W-1:0] top_waddr;
    logic [TW:0]      top_wdata;

    logic [DESC_W-1:0] desc_mem [DESC_DEPTH];
    logic [DESC_W-1:0] desc_rd_reg;
    logic              desc_we;
    logic [DAW-1:0]    desc_waddr;
    logic [DAW-1:0]    desc_raddr;
    logic [DESC_W-1:0] desc_wdata;

    logic           top_hit;
    logic           desc_valid;
    logic           start;

    assign busy      = (state_reg == S_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    assign top_hit    = top_rd_reg[TW];
    assign desc_valid = desc_rd_reg[DESC_VALID_BIT];
    assign start      = (state_reg == S_IDLE) && !q_stat.empty && (!out_valid_reg || out_ready);
    assign pop        = start;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        next_free_next = next_free_reg;
        cmd_next       = cmd_reg;
        di_next        = di_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        top_we         = 1'b0;
        top_waddr      = cmd_reg.top_idx;
        top_wdata      = '0;
        desc_we        = 1'b0;
        desc_waddr     = di_reg;
        desc_wdata     = '0;
        desc_raddr     = di_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // one descriptor per cycle; the top table is swept by the low bits
                desc_we    = 1'b1;
                desc_waddr = clr_reg;
                top_we     = 1'b1;
                top_waddr  = clr_reg[IDX_W-1:0];
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == DAW'(DESC_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = head_cmd;
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                res_next   = '0;
                state_next = S_IDLE;
                case (cmd_reg.op)
                    OP_MAP:
                    begin
                        if (top_hit)
                        begin
                            di_next    = DAW'({top_rd_reg[TW-1:0], cmd_reg.sec_idx});
                            state_next = S_DESC;
                        end
                        else if (next_free_reg < NFW'(POOL_TABLES))
                        begin
                            top_we         = 1'b1;
                            top_wdata      = {1'b1, TW'(next_free_reg)};
                            next_free_next = next_free_reg + 1'b1;
                            di_next        = DAW'({TW'(next_free_reg), cmd_reg.sec_idx});
                            state_next     = S_DESC;
                        end
                        else
                        begin
                            res_next.status = ST_NOMEM;
                            out_valid_next  = 1'b1;
                        end
                    end
                    OP_UNMAP, OP_LOOKUP:
                    begin
                        if (top_hit)
                        begin
                            di_next    = DAW'({top_rd_reg[TW-1:0], cmd_reg.sec_idx});
                            state_next = S_DESC;
                        end
                        else
                        begin
                            res_next.status = ST_ABSENT;
                            out_valid_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_OK;
                        out_valid_next  = 1'b1;
                    end
                endcase
                desc_raddr = di_next;
            end
            S_DESC:
            begin
                res_next       = '0;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                case (cmd_reg.op)
                    OP_MAP:
                    begin
                        if (desc_valid)
                        begin
                            res_next.status = ST_EXISTS;
                        end
                        else
                        begin
                            desc_we                    = 1'b1;
                            desc_wdata[DESC_VALID_BIT] = 1'b1;
                            desc_wdata[DESC_WP_BIT]    = cmd_reg.wp;
                            desc_wdata[DESC_CI_BIT]    = cmd_reg.ci;
                            desc_wdata[DESC_W-1:DESC_FRAME_LSB] = cmd_reg.frame;
                        end
                    end
                    OP_UNMAP:
                    begin
                        if (desc_valid)
                        begin
                            desc_we        = 1'b1;
                            res_next.frame = desc_rd_reg[DESC_W-1:DESC_FRAME_LSB];
                            res_next.tlb   = 1'b1;
                            res_next.rel   = cmd_reg.rel;
                        end
                        else
                        begin
                            res_next.status = ST_ABSENT;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (desc_valid)
                        begin
                            res_next.frame = desc_rd_reg[DESC_W-1:DESC_FRAME_LSB];
                            res_next.isw   = !desc_rd_reg[DESC_WP_BIT];
                            res_next.isu   = desc_rd_reg[DESC_CI_BIT];
                        end
                        else
                        begin
                            res_next.status = ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            next_free_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        di_reg  <= di_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[top_waddr] <= top_wdata;
        end
        top_rd_reg <= top_mem[head_cmd.top_idx];
    end

    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[desc_waddr] <= desc_wdata;
        end
        desc_rd_reg <= desc_mem[desc_raddr];
    end

endmodule

// ===== rtl/two_level_page_table_engine_top.sv =====
// Two-level page table engine: map, unmap and lookup of 4KB virtual pages.
//
// Requests enter on the s_axis channel (operation in tuser, page, frame and
// flags in tdata); exactly one result item leaves on m_axis per request
// (status in tuser, frame and flags in tdata).
// After rst_n is released the engine clears its descriptor memory, one entry
// per cycle, POOL_TABLES*1024 entries (16384 by default); s_axis_tready stays
// low for that time.
// A request is taken into a four-entry command queue. The walker then steps
// through pop, top table read, descriptor read and write-back for each
// request; a request settled by the top table alone (no table memory, absent
// table, unused operation code) skips the descriptor step. The walker takes
// the next command only after the current one has produced its result.
// A stalled m_axis holds the result register; the walker waits for it to
// drain before starting the next command, while the queue keeps taking
// requests until it is full.
// Second-level tables come from a pool of POOL_TABLES and are never freed.
`include "two_level_page_table_engine_top_defines.svh"

module two_level_page_table_engine_top #(
    parameter int POOL_TABLES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [19:0] virt_page, [39:20] phys_frame, [40] writeable,
    // [42:41] cache_mode, [43] release_on_unmap, [47:44] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [19:0] frame_out, [20] is_writeable, [21] is_uncached,
    // [22] tlb_invalidate, [23] release_frame
    output logic [23:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);
    import tlpt_pkg::*;

    cmd_t    push_cmd;
    cmd_t    head_cmd;
    q_stat_t q_stat;
    logic    push;
    logic    pop;
    logic    busy;
    res_t    res;

    tlpt_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .busy          (busy),
        .push          (push),
        .cmd           (push_cmd)
    );

    tlpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    tlpt_back #(
        .POOL_TABLES (POOL_TABLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_stat    (q_stat),
        .pop       (pop),
        .busy      (busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {res.rel, res.tlb, res.isu, res.isw, res.frame};
    assign m_axis_tuser = res.status;

    `TLPT_ASSERT_NOW(a_tlb_needs_ok, m_axis_tvalid && m_axis_tdata[22], m_axis_tuser == ST_OK, "tlb invalidate on a failed request")
    `TLPT_ASSERT_NOW(a_release_needs_tlb, m_axis_tvalid && m_axis_tdata[23], m_axis_tdata[22], "frame release without unmap")
    `TLPT_ASSERT_NOW(a_fail_zero_payload, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "failed request carries payload")
    `TLPT_ASSERT_NEXT(a_no_result_in_clear, busy && !m_axis_tvalid, !m_axis_tvalid, "result during clearing pass")

endmodule

// ===== tb/two_level_page_table_engine_top_test.sv =====
// Self-checking testbench for the two-level page table engine top level.
`timescale 1ns / 1ps

module two_level_page_table_engine_top_test;
    import tlpt_pkg::*;

    localparam int POOL_TABLES  = 16;
    localparam int HOT_TOPS     = 24;
    localparam int LIVE_MAX     = 64;
    localparam int RANDOM_ITEMS = 1300;
    localparam int PRESSURE_AT  = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    // descriptor clear after reset sweeps POOL_TABLES*1024 entries with no traffic
    localparam int IDLE_LIMIT   = 4 * POOL_TABLES * SECOND_ENTRIES + 4000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    class page_table_scoreboard;
        bit               top_valid [SECOND_ENTRIES];
        int unsigned      top_slot [SECOND_ENTRIES];
        bit [DESC_W-1:0]  descs [POOL_TABLES * SECOND_ENTRIES];
        int unsigned      tables_used;
        res_t             expected_results [$];
        int               mismatches;
        int               results_checked;
        int               status_seen [4];

        // update the table copy and queue the result this request produces
        function void walk_request(input logic [1:0] op, input logic [FRAME_W-1:0] vpage,
                                   input logic [FRAME_W-1:0] frame, input bit wr,
                                   input logic [1:0] pol, input bit rel);
            res_t            r;
            int              di;
            int unsigned     ti;
            bit [DESC_W-1:0] d;
            r  = '0;
            ti = vpage[19:10];
            di = -1;
            if (top_valid[ti])
                di = top_slot[ti] * SECOND_ENTRIES + vpage[9:0];
            case (op)
                OP_MAP:
                begin
                    if (di < 0)
                    begin
                        if (tables_used >= POOL_TABLES)
                            r.status = ST_NOMEM;
                        else
                        begin
                            top_valid[ti] = 1'b1;
                            top_slot[ti]  = tables_used;
                            di = tables_used * SECOND_ENTRIES + vpage[9:0];
                            tables_used++;
                        end
                    end
                    if (di >= 0)
                    begin
                        if (descs[di][DESC_VALID_BIT])
                            r.status = ST_EXISTS;
                        else
                            descs[di] = {frame, pol >= CP_MEM_NOCACHE, ~wr, 1'b1};
                    end
                end
                OP_UNMAP, OP_LOOKUP:
                begin
                    if (di < 0 || !descs[di][DESC_VALID_BIT])
                        r.status = ST_ABSENT;
                    else
                    begin
                        d       = descs[di];
                        r.frame = d[DESC_W-1:DESC_FRAME_LSB];
                        if (op == OP_UNMAP)
                        begin
                            descs[di] = '0;
                            r.tlb     = 1'b1;
                            r.rel     = rel;
                        end
                        else
                        begin
                            r.isw = ~d[DESC_WP_BIT];
                            r.isu = d[DESC_CI_BIT];
                        end
                    end
                end
                default: ;
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(input logic [1:0] status, input logic [23:0] data);
            res_t got;
            res_t want;
            got.status = status;
            got.frame  = data[19:0];
            got.isw    = data[20];
            got.isu    = data[21];
            got.tlb    = data[22];
            got.rel    = data[23];
            results_checked++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: status=%0d frame=%05h", status,
                             data[19:0]);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                status_seen[0] = status_seen[0];
            else
                status_seen[want.status]++;
            if (got.status !== want.status || got.frame !== want.frame ||
                got.isw !== want.isw || got.isu !== want.isu ||
                got.tlb !== want.tlb || got.rel !== want.rel)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at result %0d: want st=%0d fr=%05h w=%b u=%b tlb=%b rel=%b",
                             results_checked, want.status, want.frame, want.isw, want.isu,
                             want.tlb, want.rel);
                    $display("  got st=%0d fr=%05h w=%b u=%b tlb=%b rel=%b",
                             got.status, got.frame, got.isw, got.isu, got.tlb, got.rel);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    page_table_scoreboard table_model;
    bit    src_calm;
    bit    snk_calm;
    bit    sink_hold;
    int    idle_cycles;
    int    op_count [4];
    int    hot_tops [HOT_TOPS];
    logic [FRAME_W-1:0] live_pages [$];

    two_level_page_table_engine_top #(
        .POOL_TABLES(POOL_TABLES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    // offer one request and hold it until the engine takes it
    task automatic issue(input logic [1:0] op, input logic [FRAME_W-1:0] vp,
                         input logic [FRAME_W-1:0] frame, input bit wr,
                         input logic [1:0] pol, input bit rel);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, rel, pol, wr, frame, vp};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        table_model.walk_request(op, vp, frame, wr, pol, rel);
        op_count[op]++;
    endtask

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("two_level_page_table_engine_top verification failed");
            $finish;
        end
    end

    initial
    begin : result_sink
        int gap;
        int phase_left;
        phase_left = 40;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold)
            begin
                // long back-pressure so the command queue fills
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
            end
            gap = snk_calm ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            table_model.check_result(m_axis_tuser, m_axis_tdata);
            phase_left--;
            if (phase_left <= 0)
            begin
                snk_calm   = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(30, 150);
            end
        end
    end

    initial
    begin : request_source
        int pick;
        int phase_left;
        logic [1:0]         op;
        logic [IDX_W-1:0]   top;
        logic [IDX_W-1:0]   sec;
        logic [FRAME_W-1:0] vp;
        table_model   = new();
        idle_cycles   = 0;
        src_calm      = 1'b0;
        snk_calm      = 1'b0;
        sink_hold     = 1'b0;
        phase_left    = 60;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_MAP;
        hot_tops[0] = 0;
        hot_tops[1] = 1023;
        hot_tops[2] = 1;
        for (int i = 3; i < HOT_TOPS; i++)
            hot_tops[i] = $urandom_range(2, 1022);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: absent pages, duplicates, every cache policy, both flags, corner pages
        issue(OP_LOOKUP, 20'h00000, 20'h00000, 1'b0, CP_NORMAL,      1'b0);
        issue(OP_UNMAP,  20'h00000, 20'h00000, 1'b0, CP_NORMAL,      1'b1);
        issue(OP_MAP,    20'h00000, 20'hfffff, 1'b1, CP_NORMAL,      1'b0);
        issue(OP_MAP,    20'h00000, 20'h00000, 1'b0, CP_IO_NOCACHE,  1'b0);
        issue(OP_LOOKUP, 20'h00000, 20'h00000, 1'b0, CP_NORMAL,      1'b0);
        issue(OP_MAP,    20'hfffff, 20'h00000, 1'b0, CP_IO_NOCACHE,  1'b1);
        issue(OP_LOOKUP, 20'hfffff, 20'hfffff, 1'b1, CP_IO_NOCACHE,  1'b1);
        issue(OP_MAP,    20'h003ff, 20'h5a5a5, 1'b0, CP_MEM_NOCACHE, 1'b0);
        issue(OP_MAP,    20'h00001, 20'ha5a5a, 1'b1, CP_FRAMEBUFFER, 1'b0);
        issue(OP_LOOKUP, 20'h003ff, 20'h00000, 1'b0, CP_NORMAL,      1'b0);
        issue(OP_LOOKUP, 20'h00001, 20'h00000, 1'b0, CP_NORMAL,      1'b0);
        issue(OP_UNMAP,  20'h00001, 20'h00000, 1'b0, CP_NORMAL,      1'b0);
        issue(OP_UNMAP,  20'hfffff, 20'h00000, 1'b0, CP_NORMAL,      1'b1);
        issue(OP_LOOKUP, 20'hfffff, 20'h00000, 1'b0, CP_NORMAL,      1'b0);
        issue(OP_UNMAP,  20'hfffff, 20'h00000, 1'b0, CP_NORMAL,      1'b1);
        issue(OP_LOOKUP, 20'h00400, 20'h00000, 1'b0, CP_NORMAL,      1'b0);
        issue(OP_SPARE,  20'hfffff, 20'hfffff, 1'b1, CP_IO_NOCACHE,  1'b1);
        issue(OP_LOOKUP, 20'h00000, 20'h00000, 1'b0, CP_NORMAL,      1'b0);
        issue(OP_UNMAP,  20'h00000, 20'h00000, 1'b0, CP_NORMAL,      1'b1);
        issue(OP_MAP,    20'h00000, 20'h12345, 1'b0, CP_FRAMEBUFFER, 1'b0);

        // random: mostly a few hot top indices so the pool fills and pages collide
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = OP_MAP;
            else if (pick < 65)
                op = OP_UNMAP;
            else if (pick < 98)
                op = OP_LOOKUP;
            else
                op = OP_SPARE;
            if (live_pages.size() > 0 &&
                ((op != OP_MAP && $urandom_range(0, 9) < 7) ||
                 (op == OP_MAP && $urandom_range(0, 9) == 0)))
                vp = live_pages[$urandom_range(0, live_pages.size() - 1)];
            else
            begin
                top = ($urandom_range(0, 9) == 0)
                      ? IDX_W'($urandom_range(0, 1023))
                      : IDX_W'(hot_tops[$urandom_range(0, HOT_TOPS - 1)]);
                sec = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 31))
                                                 : IDX_W'($urandom_range(0, 1023));
                vp  = {top, sec};
            end
            if (op == OP_MAP)
            begin
                if (live_pages.size() < LIVE_MAX)
                    live_pages.push_back(vp);
                else
                    live_pages[$urandom_range(0, LIVE_MAX - 1)] = vp;
            end
            if (n == PRESSURE_AT)
            begin
                sink_hold  = 1'b1;
                src_calm   = 1'b1;
                phase_left = 60;
            end
            phase_left--;
            if (phase_left <= 0)
            begin
                src_calm   = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(30, 150);
            end
            issue(op, vp, FRAME_W'($urandom()), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
        s_axis_tvalid <= 1'b0;

        while (table_model.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d map, %0d unmap, %0d lookup, %0d unused code; %0d tables",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[OP_MAP],
                 op_count[OP_UNMAP], op_count[OP_LOOKUP], op_count[OP_SPARE],
                 table_model.tables_used);
        $display("Checked %0d results: ok %0d, no memory %0d, mapped %0d, absent %0d; %0d bad",
                 table_model.results_checked, table_model.status_seen[ST_OK],
                 table_model.status_seen[ST_NOMEM], table_model.status_seen[ST_EXISTS],
                 table_model.status_seen[ST_ABSENT], table_model.mismatches);
        if (table_model.mismatches == 0 && table_model.expected_results.size() == 0)
            $display("two_level_page_table_engine_top verification clean");
        else
            $display("two_level_page_table_engine_top verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tlpt_pkg.sv
rtl/tlpt_front.sv
rtl/tlpt_queue.sv
rtl/tlpt_back.sv
rtl/two_level_page_table_engine_top.sv
tb/two_level_page_table_engine_top_test.sv
